[src/segment_intersection_macros.svh]
// Assertion helpers shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment intersection check failed");
// Next-cycle implication, checked out of reset.
`define SI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment intersection check failed");
`else
`define SI_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define SI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[src/si_pkg.sv]
package si_pkg;

  // Coordinate and intermediate widths
  localparam int CB  = 16;          // coordinate bits, signed Q12.4
  localparam int DW  = CB + 1;      // coordinate difference
  localparam int PW  = 2 * DW;      // one product of differences
  localparam int XW  = PW + 1;      // cross product
  localparam int MW  = XW + DW;     // t numerator times |r|
  localparam int QW  = DW;          // quotient, never above |r|
  localparam int TW  = 4;           // tag bits

  // Divider: quotient bits resolved per stage and stage count
  localparam int BPS = 2;
  localparam int NST = (QW + BPS - 1) / BPS;

  // Divider stages plus one stage for the final add
  localparam int NS  = NST + 1;

  // Front-end stage count
  localparam int NF  = 5;

  typedef struct packed {
    logic signed [CB-1:0] ray_start_x;
    logic signed [CB-1:0] ray_start_y;
    logic signed [CB-1:0] ray_end_x;
    logic signed [CB-1:0] ray_end_y;
    logic signed [CB-1:0] edge_start_x;
    logic signed [CB-1:0] edge_start_y;
    logic signed [CB-1:0] edge_end_x;
    logic signed [CB-1:0] edge_end_y;
    logic [TW-1:0]        object_tag;
  } si_in_t;

  typedef struct packed {
    logic                 hit;
    logic [TW-1:0]        tag_out;
    logic signed [CB-1:0] point_x;
    logic signed [CB-1:0] point_y;
  } si_out_t;

  // Values that ride along the divider unchanged
  typedef struct packed {
    logic                 hit;
    logic [TW-1:0]        tag;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic                 neg_x;
    logic                 neg_y;
    logic [XW-1:0]        den;
  } si_side_t;

  // Front end to divider
  typedef struct packed {
    si_side_t      side;
    logic [MW-1:0] prod_x;
    logic [MW-1:0] prod_y;
  } si_mid_t;

endpackage

[src/si_front.sv]
`include "segment_intersection_macros.svh"

module si_front
  import si_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    stall_o,
  input  si_in_t  data_i,
  output logic    valid_o,
  input  logic    stall_i,
  output si_mid_t data_o
);

  logic [NF-1:0] v_q;
  logic [NF-1:0] en;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NF-1] = !v_q[NF-1] || !stall_i;
    for (int k = NF - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NF-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NF; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: differences
  logic signed [DW-1:0] rx_q, ry_q, sx_q, sy_q, qx_q, qy_q;
  logic signed [CB-1:0] ax1_q, ay1_q;
  logic [TW-1:0]        tag1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rx_q   <= DW'(data_i.ray_end_x) - DW'(data_i.ray_start_x);
      ry_q   <= DW'(data_i.ray_end_y) - DW'(data_i.ray_start_y);
      sx_q   <= DW'(data_i.edge_end_x) - DW'(data_i.edge_start_x);
      sy_q   <= DW'(data_i.edge_end_y) - DW'(data_i.edge_start_y);
      qx_q   <= DW'(data_i.edge_start_x) - DW'(data_i.ray_start_x);
      qy_q   <= DW'(data_i.edge_start_y) - DW'(data_i.ray_start_y);
      ax1_q  <= data_i.ray_start_x;
      ay1_q  <= data_i.ray_start_y;
      tag1_q <= data_i.object_tag;
    end
  end

  // Stage 2: products of the three cross terms
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DW-1:0] rx2_q, ry2_q;
  logic signed [CB-1:0] ax2_q, ay2_q;
  logic [TW-1:0]        tag2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p0_q   <= rx_q * sy_q;
      p1_q   <= sx_q * ry_q;
      p2_q   <= qx_q * sy_q;
      p3_q   <= sx_q * qy_q;
      p4_q   <= qx_q * ry_q;
      p5_q   <= rx_q * qy_q;
      rx2_q  <= rx_q;
      ry2_q  <= ry_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      tag2_q <= tag1_q;
    end
  end

  // Stage 3: cross products
  logic signed [XW-1:0] den3_q, tn3_q, un3_q;
  logic signed [DW-1:0] rx3_q, ry3_q;
  logic signed [CB-1:0] ax3_q, ay3_q;
  logic [TW-1:0]        tag3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      den3_q <= XW'(p0_q) - XW'(p1_q);
      tn3_q  <= XW'(p2_q) - XW'(p3_q);
      un3_q  <= XW'(p4_q) - XW'(p5_q);
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      tag3_q <= tag2_q;
    end
  end

  // Stage 4: fold the sign of den into all three, then range test
  logic signed [XW-1:0] den_n, tn_n, un_n;
  logic                 hit4_d;

  always_comb begin
    if (den3_q[XW-1]) begin
      den_n = -den3_q;
      tn_n  = -tn3_q;
      un_n  = -un3_q;
    end else begin
      den_n = den3_q;
      tn_n  = tn3_q;
      un_n  = un3_q;
    end
    hit4_d = (den3_q != '0) && !tn_n[XW-1] && !un_n[XW-1]
             && (tn_n <= den_n) && (un_n <= den_n);
  end

  logic [XW-1:0]        den4_q, tn4_q;
  logic [DW-1:0]        rxa4_q, rya4_q;
  logic                 negx4_q, negy4_q, hit4_q;
  logic signed [CB-1:0] ax4_q, ay4_q;
  logic [TW-1:0]        tag4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      den4_q  <= den_n;
      tn4_q   <= tn_n;
      hit4_q  <= hit4_d;
      rxa4_q  <= rx3_q[DW-1] ? DW'(-rx3_q) : DW'(rx3_q);
      rya4_q  <= ry3_q[DW-1] ? DW'(-ry3_q) : DW'(ry3_q);
      negx4_q <= rx3_q[DW-1];
      negy4_q <= ry3_q[DW-1];
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      tag4_q  <= tag3_q;
    end
  end

  // Stage 5: scale the t numerator by |r|
  si_mid_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_q.prod_x     <= MW'(tn4_q) * MW'(rxa4_q);
      out_q.prod_y     <= MW'(tn4_q) * MW'(rya4_q);
      out_q.side.hit   <= hit4_q;
      out_q.side.tag   <= tag4_q;
      out_q.side.ax    <= ax4_q;
      out_q.side.ay    <= ay4_q;
      out_q.side.neg_x <= negx4_q;
      out_q.side.neg_y <= negy4_q;
      out_q.side.den   <= den4_q;
    end
  end

  assign data_o = out_q;

  `SI_ASSERT_NOW(a_hit_needs_den, clk_i, rst_ni,
                 valid_o && data_o.side.hit, data_o.side.den != '0)

endmodule

[src/si_div.sv]
module si_div
  import si_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    stall_o,
  input  si_mid_t data_i,
  output logic    valid_o,
  input  logic    stall_i,
  output si_out_t data_o
);

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  si_side_t      side_q [NST];
  logic [MW-1:0] remx_q [NST];
  logic [MW-1:0] remy_q [NST];
  logic [QW-1:0] qx_q   [NST];
  logic [QW-1:0] qy_q   [NST];

  // Restoring division, BPS quotient bits per stage, both lanes share den
  for (genvar k = 0; k < NST; k++) begin : g_stage
    si_side_t      side_s;
    logic [MW-1:0] rx_s, ry_s;
    logic [QW-1:0] qx_s, qy_s;
    logic [MW-1:0] rx_d, ry_d;
    logic [QW-1:0] qx_d, qy_d;

    if (k == 0) begin : g_first
      assign side_s = data_i.side;
      assign rx_s   = data_i.prod_x;
      assign ry_s   = data_i.prod_y;
      assign qx_s   = '0;
      assign qy_s   = '0;
    end else begin : g_rest
      assign side_s = side_q[k-1];
      assign rx_s   = remx_q[k-1];
      assign ry_s   = remy_q[k-1];
      assign qx_s   = qx_q[k-1];
      assign qy_s   = qy_q[k-1];
    end

    always_comb begin
      logic [MW-1:0] trial;
      rx_d = rx_s;
      ry_d = ry_s;
      qx_d = qx_s;
      qy_d = qy_s;
      for (int j = 0; j < BPS; j++) begin
        if (QW - 1 - (k * BPS + j) >= 0) begin
          trial = MW'(side_s.den) << (QW - 1 - (k * BPS + j));
          if (rx_d >= trial) begin
            rx_d = rx_d - trial;
            qx_d = qx_d | (QW'(1) << (QW - 1 - (k * BPS + j)));
          end
          if (ry_d >= trial) begin
            ry_d = ry_d - trial;
            qy_d = qy_d | (QW'(1) << (QW - 1 - (k * BPS + j)));
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_s;
        remx_q[k] <= rx_d;
        remy_q[k] <= ry_d;
        qx_q[k]   <= qx_d;
        qy_q[k]   <= qy_d;
      end
    end
  end

  // Final stage: step from the ray start along r, zero on a miss
  si_side_t      side_l;
  logic [CB-1:0] stepx, stepy;
  si_out_t       out_q;

  assign side_l = side_q[NST-1];
  assign stepx  = side_l.neg_x ? -CB'(qx_q[NST-1]) : CB'(qx_q[NST-1]);
  assign stepy  = side_l.neg_y ? -CB'(qy_q[NST-1]) : CB'(qy_q[NST-1]);

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q.hit     <= side_l.hit;
      out_q.tag_out <= side_l.tag;
      out_q.point_x <= side_l.hit ? side_l.ax + $signed(stepx) : '0;
      out_q.point_y <= side_l.hit ? side_l.ay + $signed(stepy) : '0;
    end
  end

  assign data_o = out_q;

endmodule

[src/segment_intersection.sv]
// Pipeline: 5 front-end stages, then one stage per 2 quotient bits (9), then the
// final add.
// Throughput: one request per cycle; the pipeline stalls only while the
// output holds a result that is not taken.
// Reset: rst_ni clears all stage valid bits asynchronously; data is not reset.
`include "segment_intersection_macros.svh"

module segment_intersection
  import si_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    stall_o,
  input  si_in_t  data_i,
  output logic    valid_o,
  input  logic    stall_i,
  output si_out_t data_o
);

  logic    mid_valid;
  logic    mid_stall;
  si_mid_t mid_data;

  si_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .data_i  (data_i),
    .valid_o (mid_valid),
    .stall_i (mid_stall),
    .data_o  (mid_data)
  );

  si_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .stall_o (mid_stall),
    .data_i  (mid_data),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

  `SI_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, valid_o && !data_o.hit,
                 data_o.point_x == '0 && data_o.point_y == '0)
  `SI_ASSERT_NOW(a_backpressure, clk_i, rst_ni, stall_o, valid_o && stall_i)

endmodule
